FILE: sv/sfrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI flash read stream slave - shared definitions
// Protocol modes, command and sizing constants, and the input beat type.
// ----------------------------------------------------------------------------
package sfrs_pkg;

    localparam int ADDR_W = 24;
    localparam int WORD_W = 16;
    localparam int CNT_W  = 5;

    // Read command opcode and the word driven past the end of the ROM
    localparam logic [7:0]        READ_CMD         = 8'h03;
    localparam logic [WORD_W-1:0] ERASED_WORD      = 16'hFFFF;
    localparam logic [ADDR_W-1:0] EXPECTED_ADDR_RST = 24'h100000;

    // Bits per protocol phase
    localparam logic [CNT_W-1:0] CMD_BITS  = 5'd8;
    localparam logic [CNT_W-1:0] ADDR_BITS = 5'd24;
    localparam logic [CNT_W-1:0] WORD_BITS = 5'd16;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ADDR   = 2'd1,
        MODE_STREAM = 2'd2
    } t_mode;

    // One sample of the SPI pins plus the ROM word offered with it
    typedef struct packed {
        logic              chip_select;
        logic              serial_clock;
        logic              master_out;
        logic [WORD_W-1:0] rom_word;
        logic              rom_word_valid;
    } t_in_beat;

endpackage
`default_nettype wire

FILE: sv/sfrs_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI flash read stream slave - input register
// Captures one input beat and hands it to the protocol core; takes a new
// beat in the same cycle the held one moves on.
// ----------------------------------------------------------------------------
module sfrs_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire sfrs_pkg::t_in_beat i_beat,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output sfrs_pkg::t_in_beat     o_beat
);

    logic               r_valid;
    sfrs_pkg::t_in_beat r_beat;

    // Accept when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule
`default_nettype wire

FILE: sv/sfrs_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI flash read stream slave - protocol core
// Detects rises and falls of the sampled SPI clock, decodes command and address, shifts out ROM words
// and registers the MISO level and word-taken flag for each beat.
// ----------------------------------------------------------------------------
module sfrs_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [sfrs_pkg::ADDR_W-1:0]   i_expected_address,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire sfrs_pkg::t_in_beat            i_beat,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_master_in,
    output logic                               o_word_taken
);

    localparam int AW = sfrs_pkg::ADDR_W;
    localparam int WW = sfrs_pkg::WORD_W;
    localparam int CW = sfrs_pkg::CNT_W;

    sfrs_pkg::t_mode r_mode, n_mode;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_shift, n_shift;
    logic [WW-1:0]   r_word, n_word;
    logic            r_clk_prev, n_clk_prev;
    logic            r_miso, n_miso;
    logic            n_taken;
    logic            r_out_valid;
    logic            r_word_taken;

    logic            advance;
    logic            rise, fall;
    logic [AW-1:0]   shifted;
    logic [CW-1:0]   count_inc;
    logic [WW-1:0]   send_word;

    // Advance when the result register is free or being drained
    assign o_ready = !r_out_valid || i_ready;
    assign advance = i_valid && o_ready;

    // Edge detect and shared shift/count terms
    assign rise      = i_beat.serial_clock && !r_clk_prev;
    assign fall      = !i_beat.serial_clock && r_clk_prev;
    assign shifted   = {r_shift[AW-2:0], i_beat.master_out};
    assign count_inc = r_count + 1'b1;
    assign send_word = (r_count == '0)
                     ? (i_beat.rom_word_valid ? i_beat.rom_word : sfrs_pkg::ERASED_WORD)
                     : r_word;

    // Next mode
    always_comb begin
        n_mode = r_mode;
        if (i_beat.chip_select) begin
            n_mode = sfrs_pkg::MODE_IDLE;
        end else begin
            case (r_mode)
                sfrs_pkg::MODE_ADDR: begin
                    if (rise && count_inc >= sfrs_pkg::ADDR_BITS) begin
                        n_mode = (shifted == i_expected_address)
                               ? sfrs_pkg::MODE_STREAM : sfrs_pkg::MODE_IDLE;
                    end
                end
                sfrs_pkg::MODE_STREAM: begin
                    n_mode = sfrs_pkg::MODE_STREAM;
                end
                default: begin
                    n_mode = sfrs_pkg::MODE_IDLE;
                    if (rise && count_inc >= sfrs_pkg::CMD_BITS &&
                        shifted[7:0] == sfrs_pkg::READ_CMD) begin
                        n_mode = sfrs_pkg::MODE_ADDR;
                    end
                end
            endcase
        end
    end

    // Datapath: shifter, counter, output word and MISO
    always_comb begin
        n_count    = r_count;
        n_shift    = r_shift;
        n_word     = r_word;
        n_clk_prev = r_clk_prev;
        n_miso     = r_miso;
        n_taken    = 1'b0;
        if (i_beat.chip_select) begin
            n_count = '0;
        end else begin
            n_clk_prev = i_beat.serial_clock;
            case (r_mode)
                sfrs_pkg::MODE_ADDR: begin
                    if (rise) begin
                        n_shift = shifted;
                        n_count = (count_inc >= sfrs_pkg::ADDR_BITS) ? '0 : count_inc;
                    end
                end
                sfrs_pkg::MODE_STREAM: begin
                    if (fall) begin
                        n_word  = send_word;
                        n_taken = (r_count == '0);
                        n_miso  = send_word[~r_count[3:0]];
                        n_count = (count_inc >= sfrs_pkg::WORD_BITS) ? '0 : count_inc;
                    end
                end
                default: begin
                    if (rise) begin
                        n_shift = shifted;
                        n_count = (count_inc >= sfrs_pkg::CMD_BITS) ? '0 : count_inc;
                    end
                end
            endcase
        end
    end

    // Update protocol state once per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= sfrs_pkg::MODE_IDLE;
            r_count    <= '0;
            r_shift    <= '0;
            r_word     <= '0;
            r_clk_prev <= 1'b0;
            r_miso     <= 1'b0;
        end else if (advance) begin
            r_mode     <= n_mode;
            r_count    <= n_count;
            r_shift    <= n_shift;
            r_word     <= n_word;
            r_clk_prev <= n_clk_prev;
            r_miso     <= n_miso;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_word_taken <= n_taken;
        end
    end

    // MISO output is the held bit after this beat
    assign o_valid      = r_out_valid;
    assign o_master_in  = r_miso;
    assign o_word_taken = r_word_taken;

endmodule
`default_nettype wire

FILE: sv/spi_flash_read_stream_slave.sv
// Each accepted input beat is held in the input register, then in the core's
// result register. Throughput: one beat per cycle unless i_out_ready stalls;
// the core writes a result register, so the input register can take a beat while a result waits.
// Reset (i_rst_n low, synchronous): protocol idle, all shifters cleared,
// expected address back to 0x100000, no result pending.
`default_nettype none
// ----------------------------------------------------------------------------
// SPI flash read stream slave - top level
// Read-command (0x03) SPI flash slave working on sampled pins, one sample per
// beat, streaming 16-bit ROM words MSB first after an address match.
// ----------------------------------------------------------------------------
module spi_flash_read_stream_slave (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [sfrs_pkg::ADDR_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_chip_select,
    input  wire logic                        i_serial_clock,
    input  wire logic                        i_master_out,
    input  wire logic [sfrs_pkg::WORD_W-1:0] i_rom_word,
    input  wire logic                        i_rom_word_valid,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_master_in,
    output logic                             o_word_taken
);

    logic [sfrs_pkg::ADDR_W-1:0] r_expected_address;
    sfrs_pkg::t_in_beat          in_beat;
    sfrs_pkg::t_in_beat          core_beat;
    logic                        core_valid;
    logic                        core_ready;

    // Hold expected address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_address <= sfrs_pkg::EXPECTED_ADDR_RST;
        end else if (i_cfg_we) begin
            r_expected_address <= i_cfg_data;
        end
    end

    // Gather pin sample into one beat
    always_comb begin
        in_beat.chip_select    = i_chip_select;
        in_beat.serial_clock   = i_serial_clock;
        in_beat.master_out     = i_master_out;
        in_beat.rom_word       = i_rom_word;
        in_beat.rom_word_valid = i_rom_word_valid;
    end

    sfrs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_beat  (in_beat),
        .o_valid (core_valid),
        .i_ready (core_ready),
        .o_beat  (core_beat)
    );

    sfrs_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_expected_address (r_expected_address),
        .i_valid            (core_valid),
        .o_ready            (core_ready),
        .i_beat             (core_beat),
        .o_valid            (o_out_valid),
        .i_ready            (i_out_ready),
        .o_master_in        (o_master_in),
        .o_word_taken       (o_word_taken)
    );

endmodule
`default_nettype wire
